/* design/cpf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16/CCITT byte update for the command packet framer.
// Depends on nothing; every other design file imports it.
package cpf_pkg;

    // Field widths of one command beat.
    localparam int OPCODE_W  = 8;
    localparam int LEN_W     = 13;
    localparam int BYTE_W    = 8;
    localparam int CRC_W     = 16;

    // Input tdata: opcode, payload_length, data_byte, lowest bits first.
    localparam int S_TDATA_W = 32;

    // Output tuser bit positions.
    localparam int USR_START = 0;
    localparam int USR_END   = 1;
    localparam int USR_ERR   = 2;
    localparam int M_TUSER_W = 3;

    // Command codes.
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // Configuration register indexes.
    localparam logic REG_SYNC = 1'b0;
    localparam logic REG_MAX  = 1'b1;
    localparam int   CFG_W    = 13;

    // Reset values and limits.
    localparam logic [BYTE_W-1:0] SYNC_RESET        = 8'hAA;
    localparam logic [LEN_W-1:0]  MAX_RESET         = 13'd4096;
    localparam int                MAX_PAYLOAD_BYTES = 4096;

    // CRC-16/CCITT-FALSE.
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    // Longest burst of result beats caused by one item, and its counter width.
    localparam int BURST_MAX = 6;
    localparam int CNT_W     = $clog2(BURST_MAX + 1);

    // One result beat.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              pkt_start;
        logic              pkt_end;
        logic              err;
    } t_beat;

    // All result beats of one item, beat 0 goes out first.
    typedef struct packed {
        t_beat [BURST_MAX-1:0] beats;
        logic [CNT_W-1:0]      count;
    } t_burst;

    // One registered command item plus the CRC over opcode and length low byte.
    typedef struct packed {
        logic                command;
        logic [OPCODE_W-1:0] opcode;
        logic [LEN_W-1:0]    len;
        logic [BYTE_W-1:0]   data;
        logic [CRC_W-1:0]    hdr_crc;
    } t_item;

    // MSB-first CRC update over one byte.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* design/cpf_in_stage.sv */
`timescale 1ns / 1ps
// Input register of the framer: takes one command beat and starts the header CRC.
// Depends on cpf_pkg.
module cpf_in_stage
    import cpf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    input  logic                 i_free,
    output logic                 o_take,
    output t_item                o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  load;

    // The held item moves on as soon as the result stage has room.
    assign o_take     = r_valid && i_free;
    assign o_s_tready = !r_valid || i_free;
    assign load       = i_s_tvalid && o_s_tready;
    assign o_item     = r_item;

    // Unpack the beat and fold the opcode and length low byte into the CRC.
    always_comb begin
        n_item.command = i_s_tuser;
        n_item.opcode  = i_s_tdata[OPCODE_W-1:0];
        n_item.len     = i_s_tdata[OPCODE_W+LEN_W-1:OPCODE_W];
        n_item.data    = i_s_tdata[OPCODE_W+LEN_W+BYTE_W-1:OPCODE_W+LEN_W];
        n_item.hdr_crc = crc_byte(crc_byte(CRC_INIT, n_item.opcode),
                                  n_item.len[BYTE_W-1:0]);
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

endmodule

/* design/cpf_core.sv */
`timescale 1ns / 1ps
// Packet state, configuration registers and the burst of result beats for one item.
// Depends on cpf_pkg.
module cpf_core
    import cpf_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_take,
    input  t_item            i_item,
    output t_burst           o_burst
);

    localparam int PAR_W = $clog2(MAX_PAYLOAD + 1);
    localparam int CMP_W = (PAR_W > LEN_W) ? PAR_W : LEN_W;
    localparam logic [CMP_W-1:0] PAR_LIMIT = CMP_W'(MAX_PAYLOAD);

    logic [BYTE_W-1:0] r_sync;
    logic [LEN_W-1:0]  r_max;
    logic              r_in_packet;
    logic              n_in_packet;
    logic [LEN_W-1:0]  r_remaining;
    logic [LEN_W-1:0]  n_remaining;
    logic [CRC_W-1:0]  r_crc;
    logic [CRC_W-1:0]  n_crc;

    logic [CMP_W-1:0]  limit;
    logic [CRC_W-1:0]  hdr_crc;
    logic [CRC_W-1:0]  pay_crc;
    logic [LEN_W-1:0]  len_hi;
    logic [LEN_W-1:0]  rem_dec;
    logic              start_bad;
    logic              pay_bad;
    t_beat             err_beat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
            r_max  <= MAX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SYNC: r_sync <= i_cfg_data[BYTE_W-1:0];
                REG_MAX:  r_max  <= i_cfg_data;
                default:  r_sync <= r_sync;
            endcase
        end
    end

    // Length limit is the smaller of the register and the build-time bound.
    assign limit = (CMP_W'(r_max) < PAR_LIMIT) ? CMP_W'(r_max) : PAR_LIMIT;

    assign len_hi    = i_item.len >> BYTE_W;
    assign hdr_crc   = crc_byte(i_item.hdr_crc, len_hi[BYTE_W-1:0]);
    assign pay_crc   = crc_byte(r_crc, i_item.data);
    assign rem_dec   = r_remaining - LEN_W'(1);
    assign start_bad = r_in_packet || (CMP_W'(i_item.len) > limit);
    assign pay_bad   = !r_in_packet || (r_remaining == '0);

    always_comb begin
        err_beat.data      = '0;
        err_beat.pkt_start = 1'b0;
        err_beat.pkt_end   = 1'b0;
        err_beat.err       = 1'b1;
    end

    // Build the result beats and the next packet state.
    always_comb begin
        n_in_packet = r_in_packet;
        n_remaining = r_remaining;
        n_crc       = r_crc;
        o_burst     = '0;
        unique case (i_item.command)
            CMD_START: begin
                if (start_bad) begin
                    o_burst.beats[0] = err_beat;
                    o_burst.count    = CNT_W'(1);
                end else begin
                    o_burst.beats[0] = '{r_sync, 1'b1, 1'b0, 1'b0};
                    o_burst.beats[1] = '{i_item.opcode, 1'b0, 1'b0, 1'b0};
                    o_burst.beats[2] = '{i_item.len[BYTE_W-1:0], 1'b0, 1'b0, 1'b0};
                    o_burst.beats[3] = '{len_hi[BYTE_W-1:0], 1'b0, 1'b0, 1'b0};
                    o_burst.beats[4] = '{hdr_crc[BYTE_W-1:0], 1'b0, 1'b0, 1'b0};
                    o_burst.beats[5] = '{hdr_crc[CRC_W-1:BYTE_W], 1'b0, 1'b1, 1'b0};
                    if (i_item.len == '0) begin
                        // Empty packet closes at once; state stays idle.
                        o_burst.count = CNT_W'(6);
                    end else begin
                        o_burst.count = CNT_W'(4);
                        n_in_packet   = 1'b1;
                        n_remaining   = i_item.len;
                        n_crc         = hdr_crc;
                    end
                end
            end
            CMD_PAYLOAD: begin
                if (pay_bad) begin
                    o_burst.beats[0] = err_beat;
                    o_burst.count    = CNT_W'(1);
                end else begin
                    o_burst.beats[0] = '{i_item.data, 1'b0, 1'b0, 1'b0};
                    o_burst.beats[1] = '{pay_crc[BYTE_W-1:0], 1'b0, 1'b0, 1'b0};
                    o_burst.beats[2] = '{pay_crc[CRC_W-1:BYTE_W], 1'b0, 1'b1, 1'b0};
                    if (rem_dec == '0) begin
                        // Last payload byte: append the CRC and close the packet.
                        o_burst.count = CNT_W'(3);
                        n_in_packet   = 1'b0;
                        n_remaining   = '0;
                        n_crc         = CRC_INIT;
                    end else begin
                        o_burst.count = CNT_W'(1);
                        n_remaining   = rem_dec;
                        n_crc         = pay_crc;
                    end
                end
            end
            default: o_burst = '0;
        endcase
    end

    // Packet state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_remaining <= '0;
            r_crc       <= CRC_INIT;
        end else if (i_take) begin
            r_in_packet <= n_in_packet;
            r_remaining <= n_remaining;
            r_crc       <= n_crc;
        end
    end

endmodule

/* design/cpf_out_seq.sv */
`timescale 1ns / 1ps
// Result register of the framer: holds one burst and shifts its beats out.
// Depends on cpf_pkg.
module cpf_out_seq
    import cpf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  t_burst               i_burst,
    output logic                 o_free,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [BYTE_W-1:0]    o_m_tdata,
    output logic [M_TUSER_W-1:0] o_m_tuser,
    output logic                 o_m_tlast
);

    t_beat [BURST_MAX-1:0] r_beats;
    t_beat [BURST_MAX-1:0] n_beats;
    logic [CNT_W-1:0]      r_left;
    logic [CNT_W-1:0]      n_left;
    logic                  pop;

    assign pop    = (r_left != '0) && i_m_tready;
    assign o_free = (r_left == '0) || ((r_left == CNT_W'(1)) && i_m_tready);

    assign o_m_tvalid           = (r_left != '0);
    assign o_m_tlast            = (r_left == CNT_W'(1));
    assign o_m_tdata            = r_beats[0].data;
    assign o_m_tuser[USR_START] = r_beats[0].pkt_start;
    assign o_m_tuser[USR_END]   = r_beats[0].pkt_end;
    assign o_m_tuser[USR_ERR]   = r_beats[0].err;

    // A new burst replaces the old one; otherwise each taken beat shifts the line.
    always_comb begin
        n_beats = r_beats;
        n_left  = r_left;
        if (i_load) begin
            n_beats = i_burst.beats;
            n_left  = i_burst.count;
        end else if (pop) begin
            for (int k = 0; k < BURST_MAX - 1; k++) begin
                n_beats[k] = r_beats[k+1];
            end
            n_left = r_left - CNT_W'(1);
        end
    end

    // Beat count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    // Beat line.
    always_ff @(posedge i_clk) begin
        r_beats <= n_beats;
    end

endmodule

/* design/crc16_command_packet_framer.sv */
`timescale 1ns / 1ps
// Command packet framer with CRC-16/CCITT-FALSE: top level.
// Depends on cpf_pkg, cpf_in_stage, cpf_core and cpf_out_seq.
//
// Usage:
//   The slave stream takes command beats. tuser is the command: 0 starts a
//   packet (opcode and payload_length in tdata), 1 carries one payload byte.
//   The master stream gives one byte per beat; tuser marks packet start,
//   packet end and error, and tlast marks the final beat caused by an item.
//   A packet goes out as sync, opcode, length low, length high, payload,
//   CRC low, CRC high. The CRC covers all but the sync byte.
//   The config channel writes sync_value (index 0) or max_payload (index 1);
//   it is always ready. Write it only while the framer is idle (not enforced).
// Timing:
//   A taken command beat goes to the input register, its burst to the output
//   shift register. Payload bytes stream at one per cycle while the receiver
//   is ready; the last byte gives three beats (byte plus two CRC bytes). A start
//   gives four beats, six for an empty packet; a rejected item gives one. The
//   next item enters the output shift register only as the last beat leaves.
// Reset and stall:
//   Reset clears the open packet, the CRC and both streams, and restores the
//   registers to 0xAA and 4096. While the receiver stalls the output beat
//   holds; one more command beat is held in the input register.
module crc16_command_packet_framer
    import cpf_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Command stream.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // opcode[7:0], payload_length[20:8],
                                             // data_byte[28:21], zero[31:29]
    input  logic                 i_s_tuser,  // command
    // Byte stream.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [BYTE_W-1:0]    o_m_tdata,  // out_byte
    output logic [M_TUSER_W-1:0] o_m_tuser,  // packet_start, packet_end, error
    output logic                 o_m_tlast,  // last_of_run
    // Configuration writes.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic   take;
    logic   free;
    t_item  item;
    t_burst burst;

    assign o_cfg_ready = 1'b1;

    // Input register.
    cpf_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_free     (free),
        .o_take     (take),
        .o_item     (item)
    );

    // Packet state and burst builder.
    cpf_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_item      (item),
        .o_burst     (burst)
    );

    // Result shift register.
    cpf_out_seq u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_burst    (burst),
        .o_free     (free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

/* design/cpf_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the command packet framer, bound to the top level.
// Depends on cpf_pkg and crc16_command_packet_framer.
module cpf_checker
    import cpf_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [BYTE_W-1:0]    o_m_tdata,
    input logic [M_TUSER_W-1:0] o_m_tuser,
    input logic                 o_m_tlast
);

    // No output beat right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled output beat holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled output beat changed");

    // An error result is a lone zero byte.
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[USR_ERR] |-> o_m_tdata == '0 && o_m_tlast
            && !o_m_tuser[USR_START] && !o_m_tuser[USR_END])
        else $error("malformed error beat");

    // The CRC high byte always closes the run.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[USR_END] |-> o_m_tlast)
        else $error("packet end without tlast");

    // The sync byte is always followed by header bytes of the same run.
    a_start_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[USR_START] |-> !o_m_tlast)
        else $error("sync byte ended a run");

endmodule

bind crc16_command_packet_framer cpf_checker u_cpf_checker (.*);

/* tb/sv/crc16_command_packet_framer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the command packet framer with CRC-16/CCITT-FALSE.
// Depends on cpf_pkg and crc16_command_packet_framer; a directed table comes first,
// then random packets, all checked against an in-bench framing predictor.
module crc16_command_packet_framer_tb;
    import cpf_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int SETTLE_CYCLES = 4;     // margin for a taken beat to pass both registers
    localparam int STALL_LIMIT   = 2000;  // cycles with no beat moving on any channel
    localparam int SHORT_LEN     = 12;
    localparam int MEDIUM_LEN    = 80;
    localparam int LONG_RUN      = 48;    // payload beats streamed with no idling

    // One expected or observed output beat.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              st;
        logic              en;
        logic              err;
        logic              last;
    } result_t;

    // One row of the directed part: either a register write or a command beat.
    typedef struct {
        bit                  is_cfg;
        logic                index;
        logic [CFG_W-1:0]    value;
        logic                cmd;
        logic [OPCODE_W-1:0] opc;
        logic [LEN_W-1:0]    len;
        logic [BYTE_W-1:0]   dbyte;
        bit                  typed;
        result_t             beat;
    } row_t;

    localparam result_t REJECT_BEAT = '{data: 8'h00, st: 1'b0, en: 1'b0, err: 1'b1,
                                        last: 1'b1};

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 i_s_tuser   = CMD_START;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [BYTE_W-1:0]    o_m_tdata;
    logic [M_TUSER_W-1:0] o_m_tuser;
    logic                 o_m_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_index = REG_SYNC;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    // Typed expectation that rides along with the command beat on the bus.
    bit      row_typed = 1'b0;
    result_t row_beat  = '0;

    // Framing predictor state and its copy of the registers.
    logic              fr_open = 1'b0;
    logic [LEN_W-1:0]  fr_left = '0;
    logic [CRC_W-1:0]  fr_crc  = CRC_INIT;
    logic [BYTE_W-1:0] fr_sync = SYNC_RESET;
    logic [LEN_W-1:0]  fr_max  = MAX_RESET;

    result_t burst[$];
    result_t owed_beats[$];

    bit no_idle      = 1'b0;
    int max_len_now  = MAX_RESET;
    int sent_items   = 0;
    int n_items      = 0;
    int n_beats      = 0;
    int n_packets    = 0;
    int n_rejects    = 0;
    int n_writes     = 0;
    int failures     = 0;

    crc16_command_packet_framer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),  // opcode, payload_length, data_byte, zero pad
        .i_s_tuser   (i_s_tuser),  // command
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),  // out_byte
        .o_m_tuser   (o_m_tuser),  // packet_start, packet_end, error
        .o_m_tlast   (o_m_tlast),  // last_of_run
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever begin
            #HALF_PERIOD i_clk = ~i_clk;
        end
    end

    // Bitwise CRC-16/CCITT update, feeding the byte in MSB first.
    function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb = c[CRC_W-1] ^ b[i];
            c  = {c[CRC_W-2:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function void push_beat(input logic [BYTE_W-1:0] data, input logic st,
                            input logic en, input logic err);
        burst.push_back('{data: data, st: st, en: en, err: err, last: 1'b0});
    endfunction

    // Append both CRC bytes, low first, and close the packet.
    function void close_packet(input logic [CRC_W-1:0] crc);
        push_beat(crc[7:0], 1'b0, 1'b0, 1'b0);
        push_beat(crc[15:8], 1'b0, 1'b1, 1'b0);
        fr_open = 1'b0;
        fr_left = '0;
        fr_crc  = CRC_INIT;
    endfunction

    // Work out the output beats one command beat causes, and advance the state.
    function void frame_item(input logic cmd, input logic [OPCODE_W-1:0] opc,
                             input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] dbyte);
        logic [CRC_W-1:0] crc;
        logic [LEN_W-1:0] limit;
        burst.delete();
        limit = (fr_max > 13'(MAX_PAYLOAD_BYTES)) ? 13'(MAX_PAYLOAD_BYTES) : fr_max;
        if (cmd == CMD_START) begin
            if (fr_open || len > limit) begin
                push_beat(8'h00, 1'b0, 1'b0, 1'b1);
            end else begin
                crc = crc16_update(CRC_INIT, opc);
                crc = crc16_update(crc, len[7:0]);
                crc = crc16_update(crc, {3'b000, len[12:8]});
                push_beat(fr_sync, 1'b1, 1'b0, 1'b0);
                push_beat(opc, 1'b0, 1'b0, 1'b0);
                push_beat(len[7:0], 1'b0, 1'b0, 1'b0);
                push_beat({3'b000, len[12:8]}, 1'b0, 1'b0, 1'b0);
                if (len == '0) begin
                    close_packet(crc);
                end else begin
                    fr_open = 1'b1;
                    fr_left = len;
                    fr_crc  = crc;
                end
            end
        end else if (!fr_open || fr_left == '0) begin
            // A payload byte with no packet open is rejected.
            push_beat(8'h00, 1'b0, 1'b0, 1'b1);
        end else begin
            fr_crc = crc16_update(fr_crc, dbyte);
            push_beat(dbyte, 1'b0, 1'b0, 1'b0);
            fr_left = fr_left - 1'b1;
            if (fr_left == '0) begin
                close_packet(fr_crc);
            end
        end
        burst[$].last = 1'b1;
    endfunction

    // Receiver side: ready drops about one time in five unless idling is off.
    always @(negedge i_clk) begin
        i_m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 20);
    end

    // Monitor: register writes and command beats feed the predictor, output beats
    // are checked against the oldest expectation.
    always @(posedge i_clk) begin
        result_t got;
        result_t want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_SYNC) begin
                    fr_sync = i_cfg_data[BYTE_W-1:0];
                end else begin
                    fr_max = i_cfg_data;
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                frame_item(i_s_tuser, i_s_tdata[7:0], i_s_tdata[20:8], i_s_tdata[28:21]);
                if (row_typed) begin
                    burst[0] = row_beat;
                end
                foreach (burst[k]) begin
                    owed_beats.push_back(burst[k]);
                end
                n_items++;
            end
            if (o_m_tvalid && i_m_tready) begin
                got = '{data: o_m_tdata, st: o_m_tuser[USR_START], en: o_m_tuser[USR_END],
                        err: o_m_tuser[USR_ERR], last: o_m_tlast};
                n_beats++;
                if (owed_beats.size() == 0) begin
                    $display("%0t: unexpected beat data=%02h start=%b end=%b err=%b last=%b",
                             $time, got.data, got.st, got.en, got.err, got.last);
                    failures++;
                end else begin
                    want = owed_beats.pop_front();
                    if (got.data != want.data || got.st != want.st || got.en != want.en ||
                        got.err != want.err || got.last != want.last) begin
                        $display("%0t: mismatch expected data=%02h start=%b end=%b err=%b last=%b",
                                 $time, want.data, want.st, want.en, want.err, want.last);
                        $display("%0t:          actual   data=%02h start=%b end=%b err=%b last=%b",
                                 $time, got.data, got.st, got.en, got.err, got.last);
                        failures++;
                    end
                    if (want.en) begin
                        n_packets++;
                    end
                    if (want.err) begin
                        n_rejects++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no beat has moved on any channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("** crc16_command_packet_framer: FAILED **");
        $finish;
    end

    // Drive one command beat, with random gaps ahead of it; called and left at a
    // falling edge.
    task automatic send_item(input logic cmd, input logic [OPCODE_W-1:0] opc,
                             input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] dbyte,
                             input bit typed, input result_t beat);
        while (!no_idle && $urandom_range(99) < 20) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {3'b000, dbyte, len, opc};
        row_typed  <= typed;
        row_beat   <= beat;
        do @(posedge i_clk); while (!o_s_tready);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic send_start(input logic [OPCODE_W-1:0] opc, input logic [LEN_W-1:0] len);
        send_item(CMD_START, opc, len, BYTE_W'($urandom), 1'b0, '0);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] dbyte);
        send_item(CMD_PAYLOAD, OPCODE_W'($urandom), LEN_W'($urandom_range(4096)), dbyte,
                  1'b0, '0);
    endtask

    // Register write, only once every expected beat has come out.
    task automatic write_register(input logic index, input logic [CFG_W-1:0] value);
        i_s_tvalid <= 1'b0;
        while (owed_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == REG_MAX) begin
            max_len_now = value;
        end
        n_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        int cap;
        cap = ($urandom_range(99) < 90) ? SHORT_LEN : MEDIUM_LEN;
        if (cap > max_len_now) begin
            cap = max_len_now;
        end
        return LEN_W'($urandom_range(cap));
    endfunction

    // Mostly well-formed packets with random content; the rest are stray bytes,
    // oversized starts and starts dropped into an open packet.
    task automatic run_random(input int count);
        int               target;
        int               pick;
        logic [LEN_W-1:0] len;
        target = sent_items + count;
        while (sent_items < target) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                len = pick_len();
                send_start(OPCODE_W'($urandom), len);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(99) < 3) begin
                        send_start(OPCODE_W'($urandom), LEN_W'($urandom_range(4096)));
                    end
                    send_byte(BYTE_W'($urandom));
                end
            end else if (pick < 90 || max_len_now >= MAX_PAYLOAD_BYTES) begin
                send_byte(BYTE_W'($urandom));
            end else begin
                send_start(OPCODE_W'($urandom),
                           LEN_W'($urandom_range(MAX_PAYLOAD_BYTES, max_len_now + 1)));
            end
        end
    endtask

    function automatic row_t item_row(input logic cmd, input logic [OPCODE_W-1:0] opc,
                                      input logic [LEN_W-1:0] len,
                                      input logic [BYTE_W-1:0] dbyte,
                                      input bit typed, input result_t beat);
        row_t r;
        r = '{is_cfg: 1'b0, index: REG_SYNC, value: '0, cmd: cmd, opc: opc, len: len,
              dbyte: dbyte, typed: typed, beat: beat};
        return r;
    endfunction

    function automatic row_t cfg_row(input logic index, input logic [CFG_W-1:0] value);
        row_t r;
        r = '{is_cfg: 1'b1, index: index, value: value, cmd: CMD_START, opc: '0, len: '0,
              dbyte: '0, typed: 1'b0, beat: '0};
        return r;
    endfunction

    function automatic result_t sync_beat(input logic [BYTE_W-1:0] s);
        return '{data: s, st: 1'b1, en: 1'b0, err: 1'b0, last: 1'b0};
    endfunction

    // Stimulus: reset, directed table, random phases, then the head of a full-length
    // packet streamed with no idling.
    initial begin
        row_t directed_rows[$];
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values first, then the length limit at zero and small, sync extremes.
        directed_rows.push_back(item_row(CMD_PAYLOAD, 8'h00, 13'd0, 8'h5A, 1'b1, REJECT_BEAT));
        directed_rows.push_back(item_row(CMD_START, 8'h00, 13'd0, 8'h00, 1'b1,
                                         sync_beat(SYNC_RESET)));
        directed_rows.push_back(item_row(CMD_START, 8'hFF, 13'd0, 8'hFF, 1'b0, '0));
        directed_rows.push_back(item_row(CMD_START, 8'h12, 13'd3, 8'h00, 1'b1,
                                         sync_beat(SYNC_RESET)));
        directed_rows.push_back(item_row(CMD_START, 8'h34, 13'd1, 8'h00, 1'b1, REJECT_BEAT));
        directed_rows.push_back(item_row(CMD_PAYLOAD, 8'h00, 13'd0, 8'h00, 1'b0, '0));
        directed_rows.push_back(item_row(CMD_PAYLOAD, 8'h00, 13'd0, 8'hFF, 1'b0, '0));
        directed_rows.push_back(item_row(CMD_PAYLOAD, 8'h00, 13'd0, 8'hA5, 1'b0, '0));
        directed_rows.push_back(item_row(CMD_PAYLOAD, 8'hFF, 13'd4096, 8'h11, 1'b1,
                                         REJECT_BEAT));
        directed_rows.push_back(cfg_row(REG_MAX, 13'd0));
        directed_rows.push_back(item_row(CMD_START, 8'h01, 13'd1, 8'h00, 1'b1, REJECT_BEAT));
        directed_rows.push_back(item_row(CMD_START, 8'h02, 13'd0, 8'h00, 1'b0, '0));
        directed_rows.push_back(item_row(CMD_START, 8'h03, 13'd4095, 8'h00, 1'b1,
                                         REJECT_BEAT));
        directed_rows.push_back(item_row(CMD_START, 8'h04, 13'd4096, 8'h00, 1'b1,
                                         REJECT_BEAT));
        directed_rows.push_back(cfg_row(REG_SYNC, 13'h000));
        directed_rows.push_back(cfg_row(REG_MAX, 13'd2));
        directed_rows.push_back(item_row(CMD_START, 8'hC3, 13'd2, 8'h00, 1'b1,
                                         sync_beat(8'h00)));
        directed_rows.push_back(item_row(CMD_PAYLOAD, 8'h00, 13'd0, 8'hFF, 1'b0, '0));
        directed_rows.push_back(item_row(CMD_PAYLOAD, 8'h00, 13'd0, 8'h00, 1'b0, '0));
        directed_rows.push_back(item_row(CMD_START, 8'h7E, 13'd3, 8'h00, 1'b1, REJECT_BEAT));
        directed_rows.push_back(cfg_row(REG_SYNC, 13'h0FF));
        directed_rows.push_back(item_row(CMD_START, 8'h55, 13'd2, 8'h00, 1'b1,
                                         sync_beat(8'hFF)));
        directed_rows.push_back(item_row(CMD_START, 8'h56, 13'd0, 8'h00, 1'b1, REJECT_BEAT));
        directed_rows.push_back(item_row(CMD_PAYLOAD, 8'h00, 13'd0, 8'h3C, 1'b0, '0));
        directed_rows.push_back(item_row(CMD_PAYLOAD, 8'h00, 13'd0, 8'hC3, 1'b0, '0));

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                write_register(directed_rows[k].index, directed_rows[k].value);
            end else begin
                send_item(directed_rows[k].cmd, directed_rows[k].opc, directed_rows[k].len,
                          directed_rows[k].dbyte, directed_rows[k].typed,
                          directed_rows[k].beat);
            end
        end

        // Limit at zero: only empty packets pass.
        write_register(REG_SYNC, 13'h000);
        write_register(REG_MAX, 13'd0);
        run_random(50);

        // Widest limit with the all-ones sync byte.
        write_register(REG_SYNC, 13'h0FF);
        write_register(REG_MAX, 13'(MAX_PAYLOAD_BYTES));
        run_random(130);

        // Small random limit, so oversized starts are common.
        write_register(REG_SYNC, CFG_W'($urandom_range(255)));
        write_register(REG_MAX, CFG_W'($urandom_range(16, 1)));
        run_random(90);

        // Random settings of both registers.
        write_register(REG_SYNC, CFG_W'($urandom_range(255)));
        write_register(REG_MAX, CFG_W'($urandom_range(MAX_PAYLOAD_BYTES)));
        run_random(130);

        // A start of the largest length and a stretch of its payload with no idling
        // on either side; the packet is still open when the run ends.
        write_register(REG_SYNC, 13'h05A);
        write_register(REG_MAX, 13'(MAX_PAYLOAD_BYTES));
        no_idle = 1'b1;
        send_start(OPCODE_W'($urandom), 13'(MAX_PAYLOAD_BYTES));
        repeat (LONG_RUN) send_byte(BYTE_W'($urandom));
        no_idle = 1'b0;

        // Drain, then give any stray beat time to show up.
        i_s_tvalid <= 1'b0;
        while (owed_beats.size() != 0) @(posedge i_clk);
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (owed_beats.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, owed_beats.size());
            failures++;
        end

        $display("Run covered %0d command beats and %0d output beats after %0d register writes;",
                 n_items, n_beats, n_writes);
        $display("%0d packets were closed with a CRC and %0d items were rejected.",
                 n_packets, n_rejects);
        if (failures == 0) begin
            $display("** crc16_command_packet_framer: PASSED **");
        end else begin
            $display("** crc16_command_packet_framer: FAILED **");
        end
        $finish;
    end

endmodule

/* files.f */
design/cpf_pkg.sv
design/cpf_in_stage.sv
design/cpf_core.sv
design/cpf_out_seq.sv
design/crc16_command_packet_framer.sv
design/cpf_checker.sv
tb/sv/crc16_command_packet_framer_tb.sv
